[hw/rtl/s9wp_pkg.sv]
// ----------------------------------------------------------------------------
// s9wp_pkg
// Shared types and constants for the 9-bit word packer.
// ----------------------------------------------------------------------------
`default_nettype none

package s9wp_pkg;

    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);
    localparam int QueueCw    = $clog2(QueueDepth + 1);

    localparam logic [2:0] PhaseFull  = 3'd7;
    localparam logic [3:0] ByteBits   = 4'd8;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic       two;
        logic       last_main;
        logic       tail_en;
        logic [7:0] tail;
        logic [2:0] pad_cnt;
    } t_cmd;

endpackage

`default_nettype wire

[hw/rtl/s9wp_front.sv]
// ----------------------------------------------------------------------------
// s9wp_front
// Accepts input bytes, builds 9-bit words and splits them into output-byte
// requests for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module s9wp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_byte_value,
    input  wire logic          i_is_data,
    input  wire logic          i_end_of_transfer,
    input  wire logic          i_full,
    output logic               o_push,
    output s9wp_pkg::t_cmd     o_cmd
);

    logic [2:0]  r_phase;
    logic [6:0]  r_pending;
    logic [2:0]  n_phase;
    logic [6:0]  n_pending;
    logic [15:0] acc;
    logic [3:0]  keep;
    logic [15:0] mask;
    logic [2:0]  q;
    logic [6:0]  word_pending;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        acc  = {r_pending, i_is_data, i_byte_value};
        keep = {1'b0, r_phase} + 4'd1;
        mask = (16'd1 << keep) - 16'd1;
        o_cmd = '0;
        if (r_phase == s9wp_pkg::PhaseFull) begin
            o_cmd.b0     = acc[15:8];
            o_cmd.b1     = acc[7:0];
            o_cmd.two    = 1'b1;
            q            = 3'd0;
            word_pending = 7'd0;
        end else begin
            o_cmd.b0     = 8'(acc >> keep);
            q            = keep[2:0];
            word_pending = 7'(acc & mask);
        end
        o_cmd.last_main = i_end_of_transfer && (q == 3'd0);
        o_cmd.tail_en   = i_end_of_transfer && (q != 3'd0);
        o_cmd.tail      = 8'({1'b0, word_pending} << (s9wp_pkg::ByteBits - {1'b0, q}));
        o_cmd.pad_cnt   = 3'(s9wp_pkg::ByteBits - {1'b0, q});
        if (i_end_of_transfer) begin
            n_phase   = 3'd0;
            n_pending = 7'd0;
        end else begin
            n_phase   = q;
            n_pending = word_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 3'd0;
            r_pending <= 7'd0;
        end else if (o_push) begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/s9wp_queue.sv]
// ----------------------------------------------------------------------------
// s9wp_queue
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module s9wp_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire s9wp_pkg::t_cmd                i_cmd,
    input  wire logic                          i_pop,
    output s9wp_pkg::t_cmd                     o_head,
    output logic                               o_full,
    output logic                               o_empty,
    output logic [s9wp_pkg::QueueCw-1:0]       o_count
);

    s9wp_pkg::t_cmd                    r_mem [s9wp_pkg::QueueDepth];
    logic [s9wp_pkg::QueueAw-1:0]      r_wptr;
    logic [s9wp_pkg::QueueAw-1:0]      r_rptr;
    logic [s9wp_pkg::QueueCw-1:0]      r_count;

    assign o_head  = r_mem[r_rptr];
    assign o_full  = (r_count == s9wp_pkg::QueueCw'(s9wp_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/s9wp_back.sv]
// ----------------------------------------------------------------------------
// s9wp_back
// Walks each request through its main bytes, flush byte and zero padding,
// one output byte per cycle unless stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module s9wp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire s9wp_pkg::t_cmd     i_head,
    input  wire logic               i_empty,
    output logic                    o_pop,
    output logic                    o_tvalid,
    input  wire logic               i_tready,
    output logic [7:0]              o_tdata,
    output logic                    o_tlast
);

    typedef enum logic [1:0] {
        ST_MAIN0,
        ST_MAIN1,
        ST_TAIL,
        ST_PAD
    } t_step;

    t_step       r_step;
    t_step       n_step;
    logic [2:0]  r_pad_left;
    logic [2:0]  n_pad_left;
    logic        r_tvalid;
    logic [7:0]  r_tdata;
    logic        r_tlast;
    logic        fire;
    logic [7:0]  byte_out;
    logic        last_out;

    assign fire     = !i_empty && (!r_tvalid || i_tready);
    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

    always_comb begin
        n_step     = r_step;
        n_pad_left = r_pad_left;
        o_pop      = 1'b0;
        byte_out   = 8'd0;
        last_out   = 1'b0;
        case (r_step)
            ST_MAIN0: begin
                byte_out = i_head.b0;
                last_out = i_head.last_main && !i_head.two;
                if (i_head.two) begin
                    n_step = ST_MAIN1;
                end else if (i_head.tail_en) begin
                    n_step = ST_TAIL;
                end else begin
                    o_pop = fire;
                end
            end
            ST_MAIN1: begin
                byte_out = i_head.b1;
                last_out = i_head.last_main;
                if (i_head.tail_en) begin
                    n_step = ST_TAIL;
                end else begin
                    n_step = ST_MAIN0;
                    o_pop  = fire;
                end
            end
            ST_TAIL: begin
                byte_out   = i_head.tail;
                n_step     = ST_PAD;
                n_pad_left = i_head.pad_cnt;
            end
            ST_PAD: begin
                last_out = (r_pad_left == 3'd1);
                if (r_pad_left == 3'd1) begin
                    n_step = ST_MAIN0;
                    o_pop  = fire;
                end else begin
                    n_pad_left = r_pad_left - 3'd1;
                end
            end
            default: begin
                n_step = ST_MAIN0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= ST_MAIN0;
            r_pad_left <= 3'd0;
            r_tvalid   <= 1'b0;
            r_tdata    <= 8'd0;
            r_tlast    <= 1'b0;
        end else if (fire) begin
            r_step     <= n_step;
            r_pad_left <= n_pad_left;
            r_tvalid   <= 1'b1;
            r_tdata    <= byte_out;
            r_tlast    <= last_out;
        end else if (i_tready) begin
            r_tvalid   <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/spi_9bit_word_packer.sv]
// ----------------------------------------------------------------------------
// spi_9bit_word_packer
// Packs command/data bytes into 9-bit words for a 3-wire display link and
// emits the packed stream as bytes, padding each transfer to 72-bit blocks.
// Each input is written into the request queue, and its first output byte
// is then registered in the back end's output stage. Throughput: one output
// byte per cycle while requests are queued and the output is not stalled; an
// input yields one or two bytes, an end-of-transfer input up to nine with padding.
// A 4-entry request queue lets the input side run ahead of the output side.
// Reset (synchronous, active low) clears word phase, queue and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_9bit_word_packer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] byte_value
    input  wire logic          s_axis_tuser,   // [0] is_data
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [7:0] packed_byte
    output logic               m_axis_tlast
);

    s9wp_pkg::t_cmd                    push_cmd;
    s9wp_pkg::t_cmd                    head_cmd;
    logic                              push;
    logic                              pop;
    logic                              full;
    logic                              empty;
    logic [s9wp_pkg::QueueCw-1:0]      count;

    s9wp_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_axis_tvalid),
        .o_ready           (s_axis_tready),
        .i_byte_value      (s_axis_tdata),
        .i_is_data         (s_axis_tuser),
        .i_end_of_transfer (s_axis_tlast),
        .i_full            (full),
        .o_push            (push),
        .o_cmd             (push_cmd)
    );

    s9wp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_full  (full),
        .o_empty (empty),
        .o_count (count)
    );

    s9wp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_cmd),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= s9wp_pkg::QueueCw'(s9wp_pkg::QueueDepth))
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_pop_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> m_axis_tvalid)
        else $error("request retired without output byte");

endmodule

`default_nettype wire

[sim/spi_9bit_word_packer_test.sv]
// ----------------------------------------------------------------------------
// spi_9bit_word_packer_test
// Self-checking bench for the 9-bit word packer. Command and data requests
// go in on the input stream. A bit-level predictor packs each request into
// the expected output bytes, including the end-of-transfer flush and the
// padding to 72-bit blocks. Every output byte and its tlast are compared
// against that prediction. A directed pass covers the extremes and the
// transfer ends. Random transfers follow, with stalls on both sides. A last
// back-to-back pass runs without stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_9bit_word_packer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit   = 500;
    localparam int RandomItems  = 360;
    localparam int FinalItems   = 60;
    localparam int DrainCycles  = 20;
    localparam int MaxReports   = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] byte_value
    logic       s_axis_tuser;   // [0] is_data
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] packed_byte
    logic       m_axis_tlast;

    stream_byte_t expected_bytes[$];
    logic [2:0]   phase_words = 3'd0;
    logic [6:0]   carry_bits  = 7'd0;
    int           error_count = 0;
    int           idle_cycles = 0;
    int           items_sent  = 0;
    bit           send_stall  = 1'b0;
    bit           recv_stall  = 1'b0;

    spi_9bit_word_packer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    function automatic void push_byte(input logic [7:0] data, input logic last);
        stream_byte_t entry;
        entry.data = data;
        entry.last = last;
        expected_bytes.push_back(entry);
    endfunction

    function automatic void pack_word(input logic [7:0] value, input logic prefix,
                                      input logic eot);
        logic [15:0]  acc;
        logic [15:0]  shifted;
        logic [15:0]  mask;
        logic [3:0]   keep;
        logic [7:0]   tail_byte;
        stream_byte_t closing;
        int           pad_count;
        acc = {carry_bits, prefix, value};
        if (phase_words == 3'd7) begin
            push_byte(acc[15:8], 1'b0);
            push_byte(acc[7:0], 1'b0);
            phase_words = 3'd0;
            carry_bits  = 7'd0;
        end else begin
            keep    = {1'b0, phase_words} + 4'd1;
            shifted = acc >> keep;
            mask    = (16'd1 << keep) - 16'd1;
            push_byte(shifted[7:0], 1'b0);
            carry_bits  = acc[6:0] & mask[6:0];
            phase_words = keep[2:0];
        end
        if (eot) begin
            if (phase_words == 3'd0) begin
                closing      = expected_bytes.pop_back();
                closing.last = 1'b1;
                expected_bytes.push_back(closing);
            end else begin
                pad_count = 9 - int'(phase_words);
                tail_byte = {1'b0, carry_bits} << (4'd8 - {1'b0, phase_words});
                push_byte(tail_byte, pad_count == 1);
                for (int i = 1; i < pad_count; i++) begin
                    push_byte(8'h00, i == pad_count - 1);
                end
            end
            phase_words = 3'd0;
            carry_bits  = 7'd0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (error_count < MaxReports) begin
            $display("%0t ns: %s mismatch, got %02h want %02h", $time, what, got, want);
        end
        error_count++;
    endtask

    task automatic send_word(input logic [7:0] value, input logic prefix,
                             input logic eot);
        @(negedge i_clk);
        if (send_stall && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= prefix;
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
        pack_word(value, prefix, eot);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_transfer(input int length);
        logic prefix;
        for (int i = 0; i < length; i++) begin
            prefix = (i == 0) ? 1'b0 : 1'b1;
            if ($urandom_range(0, 7) == 0) prefix = ~prefix;
            send_word(8'($urandom_range(0, 255)), prefix, i == length - 1);
        end
    endtask

    task automatic test_directed();
        logic [7:0] block_values[8];
        block_values = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA};
        send_stall = 1'b0;
        recv_stall = 1'b0;
        // end exactly on a block boundary
        for (int i = 0; i < 8; i++) begin
            send_word(block_values[i], i[0], i == 7);
        end
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        // end one word short of a block
        for (int i = 0; i < 7; i++) begin
            send_word(block_values[7 - i], ~i[0], i == 6);
        end
        wait_drained();
    endtask

    task automatic test_random_transfers();
        int length;
        while (items_sent < RandomItems) begin
            send_stall = ($urandom_range(0, 2) != 0);
            recv_stall = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 5))
                0:       length = 8 * $urandom_range(1, 3);
                1:       length = $urandom_range(13, 30);
                default: length = $urandom_range(1, 12);
            endcase
            send_transfer(length);
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        int start_count;
        send_stall  = 1'b0;
        recv_stall  = 1'b0;
        start_count = items_sent;
        while (items_sent - start_count < FinalItems) begin
            send_transfer($urandom_range(1, 17));
        end
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_stall && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_output
        stream_byte_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected byte", m_axis_tdata, 8'h00);
            end else begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want.data) begin
                    report_mismatch("packed_byte", m_axis_tdata, want.data);
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch("last_byte", {7'd0, m_axis_tlast}, {7'd0, want.last});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("FAIL spi_9bit_word_packer");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_transfers();
        test_back_to_back();

        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (error_count == 0 && expected_bytes.size() == 0) begin
            $display("PASS spi_9bit_word_packer");
        end else begin
            $display("FAIL spi_9bit_word_packer");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/s9wp_pkg.sv
hw/rtl/s9wp_front.sv
hw/rtl/s9wp_queue.sv
hw/rtl/s9wp_back.sv
hw/rtl/spi_9bit_word_packer.sv
sim/spi_9bit_word_packer_test.sv
